/* sv/semaphore_table_with_wait_queues_macros.svh */
// Assertion macros for the semaphore table block.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef SEMAPHORE_TABLE_WITH_WAIT_QUEUES_MACROS_SVH
`define SEMAPHORE_TABLE_WITH_WAIT_QUEUES_MACROS_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stq check failed");
`define STQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stq check failed");
`else
`define STQ_ASSERT_SAME(label, ante, cons)
`define STQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/stq_pkg.sv */
// Constants, codes, sequencer states and queue pointer helper for the semaphore table.
// No dependencies.
package stq_pkg;

  localparam int NUM_SEMS    = 32;
  localparam int QUEUE_DEPTH = 32;
  localparam int NUM_TASKS   = 64;

  localparam int SEM_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SX_W  = (SEM_W > 5) ? SEM_W : 5;
  localparam int AW    = SEM_W + QW;

  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_WAIT    = 3'd1;
  localparam logic [2:0] CMD_POST    = 3'd2;
  localparam logic [2:0] CMD_DESTROY = 3'd3;
  localparam logic [2:0] CMD_PURGE   = 3'd4;

  localparam logic [1:0] STS_OK     = 2'd0;
  localparam logic [1:0] STS_UNUSED = 2'd1;
  localparam logic [1:0] STS_FULL   = 2'd2;
  localparam logic [1:0] STS_NOSLOT = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_SCAN, ST_POP_RD, ST_POP_CHK,
    ST_DES_RD, ST_DES_OUT, ST_PRG_SEM, ST_PRG_RD, ST_PRG_CHK
  } state_t;

  function automatic logic [QW-1:0] q_wrap(input logic [QW-1:0] base,
                                           input logic [QW:0] off);
    logic [QW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= (QW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (QW+1)'(QUEUE_DEPTH);
    end
    return sum[QW-1:0];
  endfunction

endpackage

/* sv/stq_queue_ram.sv */
// Wait queue entry store: one write port, one read port with registered data.
// No dependencies.
module stq_queue_ram #(
  parameter int AW = 10,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/semaphore_table_with_wait_queues.sv */
// Top level: semaphore table with FIFO wait queues under one sequencer.
// Depends on stq_pkg, stq_queue_ram and the assertion macro header.
//
//  channel | ports                               | handshake
//  input   | in_cmd .. in_live_mask              | start high, busy low
//  result  | out_status .. out_last              | out_strobe, one cycle, no stall
//
// Create scans slots one a cycle. Post pops entries one at a time
// through the single queue read port. Destroy reads out each parked
// waiter in turn. Purge visits every slot and reads each queued entry
// of the non-empty ones. Reset clears the table at once.
// Results cannot be held off; busy stays high until the last is issued.
`include "semaphore_table_with_wait_queues_macros.svh"
module semaphore_table_with_wait_queues
  import stq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [4:0]         in_sem_id,
  input  logic signed [31:0] in_initial_count,
  input  logic [5:0]         in_task_id,
  input  logic [63:0]        in_live_mask,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [4:0]         out_new_index,
  output logic               out_parked,
  output logic               out_woke_valid,
  output logic [5:0]         out_woken_task,
  output logic               out_last
);

  state_t state_r, state_nxt;

  logic             used_r [NUM_SEMS];
  logic [30:0]      cnt_r  [NUM_SEMS];
  logic [QW:0]      len_r  [NUM_SEMS];
  logic [QW-1:0]    head_r [NUM_SEMS];

  logic [2:0]       cmd_r;
  logic             sid_ok_r;
  logic [SEM_W-1:0] cur_r, cur_nxt;
  logic [30:0]      init_r;
  logic [5:0]       tid_r;
  logic [63:0]      live_r;
  logic [QW:0]      k_r, k_nxt, w_r, w_nxt, n_r, n_nxt;
  logic [QW-1:0]    h_r, h_nxt;

  logic             strobe_nxt, woke_nxt, parked_nxt, last_nxt;
  logic [1:0]       status_nxt;
  logic [4:0]       idx_nxt;
  logic [5:0]       task_nxt;
  logic             strobe_r, woke_r, parked_r, last_r;
  logic [1:0]       status_r;
  logic [4:0]       idx_r;
  logic [5:0]       task_r;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [5:0]       wdata, rdata;

  logic             used_set, used_clr, cnt_wr, len_wr, head_wr;
  logic [30:0]      cnt_val;
  logic [QW:0]      len_val;
  logic [QW-1:0]    head_val;

  logic             accept, cur_used, cur_last, tok_pos, q_full, cur_empty;
  logic             rd_live, skip_purge, valid_sem, k_end, des_last;
  logic [SX_W-1:0]  sid_x;

  function automatic logic live_chk(input logic [5:0] t, input logic [63:0] m);
    return (t != 6'd0) && ({1'b0, t} < 7'(NUM_TASKS)) && m[t];
  endfunction

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign sid_x      = SX_W'(in_sem_id);
  assign cur_used   = used_r[cur_r];
  assign cur_last   = (cur_r == SEM_W'(NUM_SEMS - 1));
  assign tok_pos    = (cnt_r[cur_r] != 31'd0);
  assign q_full     = (len_r[cur_r] >= (QW+1)'(QUEUE_DEPTH));
  assign cur_empty  = (len_r[cur_r] == '0);
  assign rd_live    = live_chk(rdata, live_r);
  assign skip_purge = (tid_r == 6'd0) || ({1'b0, tid_r} >= 7'(NUM_TASKS)) ||
                      live_chk(tid_r, live_r);
  assign valid_sem  = sid_ok_r && cur_used;
  assign k_end      = (k_r == n_r);
  assign des_last   = ((k_r + 1'b1) == n_r);

  stq_queue_ram #(.AW(AW), .DW(6)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        state_nxt = ST_IDLE;
        if (cmd_r == CMD_CREATE) begin
          state_nxt = ST_SCAN;
        end else if (cmd_r == CMD_POST && valid_sem) begin
          state_nxt = ST_POP_RD;
        end else if (cmd_r == CMD_DESTROY && valid_sem && !cur_empty) begin
          state_nxt = ST_DES_RD;
        end else if (cmd_r == CMD_PURGE && !skip_purge) begin
          state_nxt = ST_PRG_SEM;
        end
      end
      ST_SCAN: begin
        if (!cur_used || cur_last) state_nxt = ST_IDLE;
      end
      ST_POP_RD: begin
        state_nxt = cur_empty ? ST_IDLE : ST_POP_CHK;
      end
      ST_POP_CHK: begin
        state_nxt = rd_live ? ST_IDLE : ST_POP_RD;
      end
      ST_DES_RD:  state_nxt = ST_DES_OUT;
      ST_DES_OUT: begin
        state_nxt = des_last ? ST_IDLE : ST_DES_RD;
      end
      ST_PRG_SEM: begin
        if (cur_used && !cur_empty) state_nxt = ST_PRG_RD;
        else if (cur_last) state_nxt = ST_IDLE;
      end
      ST_PRG_RD: begin
        if (!k_end) state_nxt = ST_PRG_CHK;
        else if (cur_last) state_nxt = ST_IDLE;
        else state_nxt = ST_PRG_SEM;
      end
      ST_PRG_CHK: state_nxt = ST_PRG_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    strobe_nxt = 1'b0;
    status_nxt = STS_OK;
    idx_nxt    = '0;
    parked_nxt = 1'b0;
    woke_nxt   = 1'b0;
    task_nxt   = '0;
    last_nxt   = 1'b1;
    cur_nxt    = cur_r;
    k_nxt      = k_r;
    w_nxt      = w_r;
    n_nxt      = n_r;
    h_nxt      = h_r;
    we         = 1'b0;
    waddr      = {cur_r, q_wrap(head_r[cur_r], len_r[cur_r])};
    wdata      = tid_r;
    raddr      = {cur_r, head_r[cur_r]};
    used_set   = 1'b0;
    used_clr   = 1'b0;
    cnt_wr     = 1'b0;
    cnt_val    = cnt_r[cur_r];
    len_wr     = 1'b0;
    len_val    = len_r[cur_r];
    head_wr    = 1'b0;
    head_val   = head_r[cur_r];
    case (state_r)
      ST_IDLE: begin
        if (accept) cur_nxt = sid_x[SEM_W-1:0];
      end
      ST_DISP: begin
        case (cmd_r)
          CMD_CREATE: cur_nxt = '0;
          CMD_WAIT, CMD_POST, CMD_DESTROY: begin
            if (!valid_sem) begin
              strobe_nxt = 1'b1;
              status_nxt = STS_UNUSED;
            end else if (cmd_r == CMD_WAIT) begin
              strobe_nxt = 1'b1;
              if (tok_pos) begin
                cnt_wr  = 1'b1;
                cnt_val = cnt_r[cur_r] - 31'd1;
              end else if (q_full) begin
                status_nxt = STS_FULL;
              end else begin
                we         = 1'b1;
                len_wr     = 1'b1;
                len_val    = len_r[cur_r] + 1'b1;
                parked_nxt = 1'b1;
              end
            end else if (cmd_r == CMD_DESTROY) begin
              used_clr = 1'b1;
              len_wr   = 1'b1;
              len_val  = '0;
              n_nxt    = len_r[cur_r];
              h_nxt    = head_r[cur_r];
              k_nxt    = '0;
              if (cur_empty) strobe_nxt = 1'b1;
            end
          end
          CMD_PURGE: begin
            cur_nxt = '0;
            if (skip_purge) strobe_nxt = 1'b1;
          end
          default: strobe_nxt = 1'b1;
        endcase
      end
      ST_SCAN: begin
        if (!cur_used) begin
          used_set   = 1'b1;
          cnt_wr     = 1'b1;
          cnt_val    = init_r;
          len_wr     = 1'b1;
          len_val    = '0;
          head_wr    = 1'b1;
          head_val   = '0;
          strobe_nxt = 1'b1;
          idx_nxt    = 5'(cur_r);
        end else if (cur_last) begin
          strobe_nxt = 1'b1;
          status_nxt = STS_NOSLOT;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      ST_POP_RD: begin
        if (cur_empty) begin
          strobe_nxt = 1'b1;
          if (cnt_r[cur_r] != 31'h7FFFFFFF) begin
            cnt_wr  = 1'b1;
            cnt_val = cnt_r[cur_r] + 31'd1;
          end
        end
      end
      ST_POP_CHK: begin
        head_wr  = 1'b1;
        head_val = q_wrap(head_r[cur_r], (QW+1)'(1));
        len_wr   = 1'b1;
        len_val  = len_r[cur_r] - 1'b1;
        if (rd_live) begin
          strobe_nxt = 1'b1;
          woke_nxt   = 1'b1;
          task_nxt   = rdata;
        end
      end
      ST_DES_RD: begin
        raddr = {cur_r, q_wrap(h_r, k_r)};
      end
      ST_DES_OUT: begin
        strobe_nxt = 1'b1;
        woke_nxt   = 1'b1;
        task_nxt   = rdata;
        last_nxt   = des_last;
        k_nxt      = k_r + 1'b1;
      end
      ST_PRG_SEM: begin
        if (cur_used && !cur_empty) begin
          k_nxt = '0;
          w_nxt = '0;
          n_nxt = len_r[cur_r];
          h_nxt = head_r[cur_r];
        end else if (cur_last) begin
          strobe_nxt = 1'b1;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      ST_PRG_RD: begin
        raddr = {cur_r, q_wrap(h_r, k_r)};
        if (k_end) begin
          len_wr  = 1'b1;
          len_val = w_r;
          if (cur_last) strobe_nxt = 1'b1;
          else cur_nxt = cur_r + 1'b1;
        end
      end
      ST_PRG_CHK: begin
        k_nxt = k_r + 1'b1;
        if (rdata != tid_r) begin
          we    = 1'b1;
          waddr = {cur_r, q_wrap(h_r, w_r)};
          wdata = rdata;
          w_nxt = w_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
      cur_r    <= '0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        used_r[i] <= 1'b0;
        cnt_r[i]  <= '0;
        len_r[i]  <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      cur_r    <= cur_nxt;
      if (used_set) used_r[cur_r] <= 1'b1;
      if (used_clr) used_r[cur_r] <= 1'b0;
      if (cnt_wr)   cnt_r[cur_r]  <= cnt_val;
      if (len_wr)   len_r[cur_r]  <= len_val;
    end
  end

  always_ff @(posedge clk) begin
    if (head_wr) head_r[cur_r] <= head_val;
    if (accept) begin
      cmd_r    <= in_cmd;
      sid_ok_r <= ({1'b0, sid_x} < (SX_W+1)'(NUM_SEMS));
      init_r   <= in_initial_count[31] ? 31'd0 : in_initial_count[30:0];
      tid_r    <= in_task_id;
      live_r   <= in_live_mask;
    end
    k_r      <= k_nxt;
    w_r      <= w_nxt;
    n_r      <= n_nxt;
    h_r      <= h_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    parked_r <= parked_nxt;
    woke_r   <= woke_nxt;
    task_r   <= task_nxt;
    last_r   <= last_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_new_index  = idx_r;
  assign out_parked     = parked_r;
  assign out_woke_valid = woke_r;
  assign out_woken_task = task_r;
  assign out_last       = last_r;

  `STQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `STQ_ASSERT_NEXT(a_more_results, out_strobe && !out_last, busy)
  `STQ_ASSERT_SAME(a_len_bound, 1'b1, len_r[cur_r] <= (QW+1)'(QUEUE_DEPTH))

endmodule

/* test/tb_semaphore_table_with_wait_queues.sv */
// Self-checking bench for the semaphore table with FIFO wait queues.
// Predicts each command's results with its own copy of the table; needs stq_pkg and the top level.
module tb_semaphore_table_with_wait_queues;
  import stq_pkg::*;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  sem;
    logic [31:0] init;
    logic [5:0]  tid;
    logic [63:0] live;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] idx;
    logic       parked;
    logic       woke;
    logic [5:0] task_no;
    logic       last;
  } sem_result_t;

  logic clk, rst_n, start, busy;
  logic [2:0] in_cmd;
  logic [4:0] in_sem_id;
  logic signed [31:0] in_initial_count;
  logic [5:0] in_task_id;
  logic [63:0] in_live_mask;
  logic out_strobe, out_parked, out_woke_valid, out_last;
  logic [1:0] out_status;
  logic [4:0] out_new_index;
  logic [5:0] out_woken_task;

  semaphore_table_with_wait_queues u_dut (.*);

  cmd_item_t   pending_cmds[$];
  sem_result_t expected_results[$];
  int errors = 0, accepted = 0, results_seen = 0, cycles = 0, gap = 0, burst = 0;
  bit hold_off = 0, driving_done = 0;

  bit          used_m[NUM_SEMS];
  logic [30:0] tokens_m[NUM_SEMS];
  logic [5:0]  waiters_m[NUM_SEMS][$];
  int          parks_total = 0, wakes_total = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit task_live(logic [5:0] t, logic [63:0] m);
    return t != 0 && m[t];
  endfunction

  function automatic sem_result_t mk(logic [1:0] st, logic [4:0] ix, logic pk,
                                     logic wk, logic [5:0] tk, logic ls);
    sem_result_t r;
    r.status = st; r.idx = ix; r.parked = pk; r.woke = wk; r.task_no = tk; r.last = ls;
    return r;
  endfunction

  task automatic predict_command(cmd_item_t c);
    logic [5:0] h;
    logic [5:0] kept[$];
    int n;
    bit found;
    case (c.cmd)
      CMD_CREATE: begin
        found = 0;
        for (int s = 0; s < NUM_SEMS && !found; s++) begin
          if (!used_m[s]) begin
            found = 1;
            used_m[s] = 1;
            tokens_m[s] = c.init[31] ? 31'd0 : c.init[30:0];
            waiters_m[s].delete();
            expected_results.push_back(mk(STS_OK, 5'(s), 0, 0, 0, 1));
          end
        end
        if (!found) expected_results.push_back(mk(STS_NOSLOT, 0, 0, 0, 0, 1));
      end
      CMD_WAIT, CMD_POST, CMD_DESTROY: begin
        if (!used_m[c.sem]) begin
          expected_results.push_back(mk(STS_UNUSED, 0, 0, 0, 0, 1));
        end else if (c.cmd == CMD_WAIT) begin
          if (tokens_m[c.sem] != 0) begin
            tokens_m[c.sem]--;
            expected_results.push_back(mk(STS_OK, 0, 0, 0, 0, 1));
          end else if (waiters_m[c.sem].size() >= QUEUE_DEPTH) begin
            expected_results.push_back(mk(STS_FULL, 0, 0, 0, 0, 1));
          end else begin
            waiters_m[c.sem].push_back(c.tid);
            parks_total++;
            expected_results.push_back(mk(STS_OK, 0, 1, 0, 0, 1));
          end
        end else if (c.cmd == CMD_POST) begin
          found = 0;
          while (!found && waiters_m[c.sem].size() > 0) begin
            h = waiters_m[c.sem].pop_front();
            if (task_live(h, c.live)) found = 1;
          end
          if (found) begin
            wakes_total++;
            expected_results.push_back(mk(STS_OK, 0, 0, 1, h, 1));
          end else begin
            if (tokens_m[c.sem] != 31'h7FFFFFFF) tokens_m[c.sem]++;
            expected_results.push_back(mk(STS_OK, 0, 0, 0, 0, 1));
          end
        end else begin
          n = waiters_m[c.sem].size();
          used_m[c.sem] = 0;
          if (n == 0) expected_results.push_back(mk(STS_OK, 0, 0, 0, 0, 1));
          for (int k = 0; k < n; k++)
            expected_results.push_back(mk(STS_OK, 0, 0, 1, waiters_m[c.sem][k], k == n - 1));
          waiters_m[c.sem].delete();
        end
      end
      CMD_PURGE: begin
        if (c.tid != 0 && !c.live[c.tid]) begin
          for (int s = 0; s < NUM_SEMS; s++) begin
            if (used_m[s]) begin
              kept.delete();
              foreach (waiters_m[s][k]) if (waiters_m[s][k] != c.tid) kept.push_back(waiters_m[s][k]);
              waiters_m[s] = kept;
            end
          end
        end
        expected_results.push_back(mk(STS_OK, 0, 0, 0, 0, 1));
      end
      default: expected_results.push_back(mk(STS_OK, 0, 0, 0, 0, 1));
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        accepted++;
        predict_command({in_cmd, in_sem_id, in_initial_count, in_task_id, in_live_mask});
      end
      if (start && !busy || !start) begin
        if (pending_cmds.size() == 0 || hold_off) begin
          start <= 0;
        end else if (gap > 0) begin
          gap--;
          start <= 0;
        end else begin
          {in_cmd, in_sem_id, in_initial_count, in_task_id, in_live_mask} <=
            pending_cmds.pop_front();
          start <= 1;
          if (burst > 0) burst--;
          else begin
            burst = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    sem_result_t g, e;
    if (rst_n && out_strobe) begin
      results_seen++;
      g = mk(out_status, out_new_index, out_parked, out_woke_valid, out_woken_task, out_last);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = expected_results.pop_front();
        if (g.status !== e.status) report_mismatch("status", g.status, e.status);
        if (g.idx !== e.idx) report_mismatch("new_index", g.idx, e.idx);
        if (g.parked !== e.parked) report_mismatch("parked", g.parked, e.parked);
        if (g.woke !== e.woke) report_mismatch("woke_valid", g.woke, e.woke);
        if (g.task_no !== e.task_no) report_mismatch("woken_task", g.task_no, e.task_no);
        if (g.last !== e.last) report_mismatch("last", g.last, e.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 5000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic cmd_item_t item(logic [2:0] c, logic [4:0] s, logic [31:0] i,
                                     logic [5:0] t, logic [63:0] m);
    cmd_item_t x;
    x.cmd = c; x.sem = s; x.init = i; x.tid = t; x.live = m;
    return x;
  endfunction

  function automatic logic [63:0] rand_mask();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [4:0] pick_sem();
    return 5'($urandom_range(0, 5) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 3));
  endfunction

  initial begin
    rst_n = 0; start = 0;
    in_cmd = 0; in_sem_id = 0; in_initial_count = 0; in_task_id = 0; in_live_mask = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    pending_cmds.push_back(item(CMD_WAIT, 5'd31, 0, 6'd5, '1));
    pending_cmds.push_back(item(CMD_POST, 5'd0, 0, 0, '1));
    pending_cmds.push_back(item(CMD_DESTROY, 5'd7, 0, 0, '1));
    pending_cmds.push_back(item(CMD_CREATE, 0, 32'h8000_0000, 0, 0));
    pending_cmds.push_back(item(CMD_CREATE, 0, 32'h7FFF_FFFF, 0, 0));
    pending_cmds.push_back(item(CMD_POST, 5'd1, 0, 0, 0));
    pending_cmds.push_back(item(CMD_WAIT, 5'd1, 0, 6'd63, 0));
    pending_cmds.push_back(item(CMD_WAIT, 5'd0, 0, 6'd0, 0));
    pending_cmds.push_back(item(CMD_WAIT, 5'd0, 0, 6'd63, 0));
    pending_cmds.push_back(item(CMD_WAIT, 5'd0, 0, 6'd9, 0));
    pending_cmds.push_back(item(CMD_WAIT, 5'd0, 0, 6'd10, 0));
    pending_cmds.push_back(item(CMD_POST, 5'd0, 0, 0, 64'h400));
    pending_cmds.push_back(item(CMD_PURGE, 0, 0, 6'd0, 0));
    pending_cmds.push_back(item(CMD_PURGE, 0, 0, 6'd9, 64'h200));
    pending_cmds.push_back(item(CMD_WAIT, 5'd0, 0, 6'd9, 0));
    pending_cmds.push_back(item(CMD_PURGE, 0, 0, 6'd9, 0));
    pending_cmds.push_back(item(3'd5, 0, 0, 0, 0));
    pending_cmds.push_back(item(3'd7, 5'd31, '1, '1, '1));
    pending_cmds.push_back(item(CMD_DESTROY, 5'd0, 0, 0, 0));
    for (int k = 0; k < 34; k++) pending_cmds.push_back(item(CMD_CREATE, 0, 0, 0, 0));
    for (int k = 0; k < 33; k++)
      pending_cmds.push_back(item(CMD_WAIT, 5'd0, 0, 6'(k + 1), 0));
    pending_cmds.push_back(item(CMD_DESTROY, 5'd0, 0, 0, 0));
    for (int k = 1; k < 32; k++) pending_cmds.push_back(item(CMD_DESTROY, 5'(k), 0, 0, 0));

    wait (pending_cmds.size() == 0 && !start);
    hold_off = 1;
    wait (expected_results.size() == 0);
    repeat (4) @(posedge clk);
    hold_off = 0;

    for (int k = 0; k < 352; k++) begin
      case ($urandom_range(0, 19))
        0, 1:  pending_cmds.push_back(item(CMD_CREATE, 0, $urandom_range(0, 3) == 0 ?
                 $urandom : $urandom_range(0, 2), 0, 0));
        2, 3, 4, 5, 6, 7:
               pending_cmds.push_back(item(CMD_WAIT, pick_sem(), $urandom,
                 6'($urandom_range(0, 63)), rand_mask()));
        8, 9, 10, 11, 12:
               pending_cmds.push_back(item(CMD_POST, pick_sem(), $urandom,
                 6'($urandom), rand_mask() | ($urandom_range(0, 1) ? '1 : '0)));
        13, 14: pending_cmds.push_back(item(CMD_DESTROY, pick_sem(), $urandom, 6'($urandom),
                 rand_mask()));
        15, 16, 17: pending_cmds.push_back(item(CMD_PURGE, 5'($urandom), $urandom,
                 6'($urandom), rand_mask()));
        18:    pending_cmds.push_back(item(3'($urandom_range(5, 7)), 5'($urandom), $urandom,
                 6'($urandom), rand_mask()));
        default: pending_cmds.push_back(item(CMD_POST, 0, 0, 0, '1));
      endcase
    end

    wait (pending_cmds.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d commands accepted, %0d results checked", accepted, results_seen);
    $display("%0d callers parked, %0d woken by post", parks_total, wakes_total);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
